// File: design/suie_pkg.sv
// ----------------------------------------------------------------------------
// suie_pkg
// Shared types, constants and helpers for the sorted union insert engine.
// ----------------------------------------------------------------------------
package suie_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int TOTAL_W     = 7;
   localparam int POS_W       = $clog2(DEPTH + 1);
   localparam int LOG_D       = $clog2(DEPTH);

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_MERGE  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DATA_W-1:0]   value;
      logic        [INDEX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   read_value;
      logic        [TOTAL_W-1:0]  entry_total;
      status_type                 status;
      logic        [TOTAL_W-1:0]  place;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic shift;
   } cell_cmd_type;

   typedef struct packed {
      logic              dup;
      logic [POS_W-1:0]  place;
      logic [DEPTH-1:0]  ins_load;
      logic [DEPTH-1:0]  ins_shift;
      logic [DEPTH-1:0]  tail;
   } locate_type;

   function automatic logic signed [VALUE_WIDTH-1:0] fit_value(
      input logic signed [DATA_W-1:0] raw);
      logic signed [63:0] wide;
      wide = 64'(raw);
      return wide[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] out_value(
      input logic signed [VALUE_WIDTH-1:0] entry);
      logic signed [63:0] wide;
      wide = 64'(entry);
      return wide[DATA_W-1:0];
   endfunction

endpackage

// File: design/suie_cell.sv
// ----------------------------------------------------------------------------
// suie_cell
// One entry of the ordered store: compare flags, read tap, load or shift.
// ----------------------------------------------------------------------------
module suie_cell (
   input  logic                                        clock,
   input  suie_pkg::cell_cmd_type                      cmd,
   input  logic        [suie_pkg::POS_W-1:0]           pos,
   input  logic        [suie_pkg::INDEX_W-1:0]         index,
   input  logic signed [suie_pkg::VALUE_WIDTH-1:0]     cmp_value,
   input  logic signed [suie_pkg::VALUE_WIDTH-1:0]     load_value,
   input  logic signed [suie_pkg::VALUE_WIDTH-1:0]     left_entry,
   output logic signed [suie_pkg::VALUE_WIDTH-1:0]     entry,
   output logic                                        ge,
   output logic                                        eq,
   output logic signed [suie_pkg::VALUE_WIDTH-1:0]     tap
);

   logic signed [suie_pkg::VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                                    ge_ff, ge_in;
   logic                                    eq_ff, eq_in;
   logic                                    hit_ff, hit_in;

   always_comb begin
      priority if (cmd.load) begin
         entry_in = load_value;
      end else if (cmd.shift) begin
         entry_in = left_entry;
      end else begin
         entry_in = entry_ff;
      end
      if (cmd.capture) begin
         ge_in  = entry_ff >= cmp_value;
         eq_in  = entry_ff == cmp_value;
         hit_in = 32'(index) == 32'(pos);
      end else begin
         ge_in  = ge_ff;
         eq_in  = eq_ff;
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      ge_ff    <= ge_in;
      eq_ff    <= eq_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign ge    = ge_ff;
   assign eq    = eq_ff;
   assign tap   = hit_ff ? entry_ff : '0;

endmodule

// File: design/suie_locate.sv
// ----------------------------------------------------------------------------
// suie_locate
// Find the first live cell at or above the value and build the insert masks.
// ----------------------------------------------------------------------------
module suie_locate (
   input  logic [suie_pkg::DEPTH-1:0]  ge_vec,
   input  logic [suie_pkg::DEPTH-1:0]  eq_vec,
   input  logic [suie_pkg::POS_W-1:0]  count,
   output suie_pkg::locate_type        loc
);

   logic [suie_pkg::DEPTH-1:0] live;
   logic [suie_pkg::DEPTH-1:0] tail;
   logic [suie_pkg::DEPTH-1:0] stop;
   logic [suie_pkg::DEPTH-1:0] pre;
   logic [suie_pkg::DEPTH-1:0] first;
   logic [suie_pkg::POS_W-1:0] k;
   logic                       found;

   always_comb begin
      for (int i = 0; i < suie_pkg::DEPTH; i++) begin
         live[i] = suie_pkg::POS_W'(i) < count;
         tail[i] = suie_pkg::POS_W'(i) == count;
      end
      stop = ge_vec & live;
      pre  = stop;
      for (int l = 0; l < suie_pkg::LOG_D; l++) begin
         pre = pre | (pre << (1 << l));
      end
      first = stop & ~(pre << 1);
      found = |stop;
      k     = '0;
      for (int i = 0; i < suie_pkg::DEPTH; i++) begin
         k = k | (first[i] ? suie_pkg::POS_W'(i) : '0);
      end
      loc.dup       = |(first & eq_vec);
      loc.place     = found ? k : count;
      loc.ins_load  = found ? first : tail;
      loc.ins_shift = pre & ~first & (live | tail);
      loc.tail      = tail;
   end

endmodule

// File: design/sorted_union_insert_engine.sv
// ----------------------------------------------------------------------------
// sorted_union_insert_engine
// Ordered store held in a row of compare-and-shift cells, with a count.
// A request is taken in the idle state (cells capture compare flags) and
// resolved in the apply state (locate, shift, load); the response is
// registered. A new request is not taken until the previous one is applied;
// a held response holds apply and so stalls the next request.
// Reset: synchronous; clears the count, control state and response valid.
// ----------------------------------------------------------------------------
module sorted_union_insert_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  suie_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output suie_pkg::rsp_type  rsp_payload
);

   suie_pkg::state_type                         state_ff, state_in;
   logic [suie_pkg::POS_W-1:0]                  count_ff, count_in;
   suie_pkg::kind_type                          kind_ff, kind_in;
   logic signed [suie_pkg::VALUE_WIDTH-1:0]     value_ff, value_in;
   logic [suie_pkg::INDEX_W-1:0]                index_ff, index_in;
   logic                                        rsp_valid_ff, rsp_valid_in;
   suie_pkg::rsp_type                           rsp_ff, rsp_in;

   logic signed [suie_pkg::VALUE_WIDTH-1:0]     cmp_value;
   logic signed [suie_pkg::VALUE_WIDTH-1:0]     entry_vec [suie_pkg::DEPTH];
   logic signed [suie_pkg::VALUE_WIDTH-1:0]     tap_vec   [suie_pkg::DEPTH];
   logic [suie_pkg::DEPTH-1:0]                  ge_vec, eq_vec;
   logic [suie_pkg::DEPTH-1:0]                  load_vec, shift_vec;
   logic signed [suie_pkg::VALUE_WIDTH-1:0]     rd_acc;
   suie_pkg::locate_type                        loc;
   logic                                        accept, apply_go, full, write_en, in_range;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != suie_pkg::ST_IDLE;
   assign apply_go  = (state_ff == suie_pkg::ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign cmp_value = suie_pkg::fit_value(req_payload.value);
   assign full      = count_ff == suie_pkg::POS_W'(suie_pkg::DEPTH);
   assign in_range  = 32'(index_ff) < 32'(count_ff);

   suie_locate u_locate (
      .ge_vec (ge_vec),
      .eq_vec (eq_vec),
      .count  (count_ff),
      .loc    (loc)
   );

   always_comb begin
      unique case (kind_ff)
         suie_pkg::KIND_APPEND: write_en = apply_go && !full;
         suie_pkg::KIND_MERGE:  write_en = apply_go && !full && !loc.dup;
         default:               write_en = 1'b0;
      endcase
      if (kind_ff == suie_pkg::KIND_APPEND) begin
         load_vec  = write_en ? loc.tail : '0;
         shift_vec = '0;
      end else begin
         load_vec  = write_en ? loc.ins_load : '0;
         shift_vec = write_en ? loc.ins_shift : '0;
      end
   end

   for (genvar i = 0; i < suie_pkg::DEPTH; i++) begin : g_cell
      suie_pkg::cell_cmd_type                  cmd;
      logic signed [suie_pkg::VALUE_WIDTH-1:0] left;

      assign cmd = '{capture: accept, load: load_vec[i], shift: shift_vec[i]};

      if (i == 0) begin : g_head
         assign left = value_ff;
      end else begin : g_body
         assign left = entry_vec[i-1];
      end

      suie_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (suie_pkg::POS_W'(i)),
         .index      (req_payload.index),
         .cmp_value  (cmp_value),
         .load_value (value_ff),
         .left_entry (left),
         .entry      (entry_vec[i]),
         .ge         (ge_vec[i]),
         .eq         (eq_vec[i]),
         .tap        (tap_vec[i])
      );
   end

   always_comb begin
      rd_acc = '0;
      for (int i = 0; i < suie_pkg::DEPTH; i++) begin
         rd_acc = rd_acc | tap_vec[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         suie_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in  = req_payload.kind;
               value_in = cmp_value;
               index_in = req_payload.index;
               state_in = suie_pkg::ST_APPLY;
            end
         end
         suie_pkg::ST_APPLY: begin
            if (apply_go) begin
               state_in           = suie_pkg::ST_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.read_value  = '0;
               rsp_in.status      = suie_pkg::STAT_DONE;
               rsp_in.place       = '0;
               unique case (kind_ff)
                  suie_pkg::KIND_APPEND: begin
                     if (full) begin
                        rsp_in.status = suie_pkg::STAT_FULL;
                     end else begin
                        rsp_in.place = suie_pkg::TOTAL_W'(count_ff);
                        count_in     = suie_pkg::POS_W'(count_ff + 1'b1);
                     end
                  end
                  suie_pkg::KIND_MERGE: begin
                     if (loc.dup) begin
                        rsp_in.status = suie_pkg::STAT_DUP;
                        rsp_in.place  = suie_pkg::TOTAL_W'(loc.place);
                     end else if (full) begin
                        rsp_in.status = suie_pkg::STAT_FULL;
                     end else begin
                        rsp_in.place = suie_pkg::TOTAL_W'(loc.place);
                        count_in     = suie_pkg::POS_W'(count_ff + 1'b1);
                     end
                  end
                  suie_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  suie_pkg::KIND_READ: begin
                     if (in_range) begin
                        rsp_in.read_value = suie_pkg::out_value(rd_acc);
                     end else begin
                        rsp_in.status = suie_pkg::STAT_RANGE;
                     end
                  end
               endcase
               rsp_in.entry_total = suie_pkg::TOTAL_W'(count_in);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= suie_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      index_ff <= index_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= suie_pkg::POS_W'(suie_pkg::DEPTH))
      else $error("entry count above depth");

   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == suie_pkg::ST_APPLY)
      else $error("accepted request did not move to apply");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec) && (!write_en || $onehot(load_vec)))
      else $error("cell load not one-hot");

   a_no_shift_idle: assert property (@(posedge clock) disable iff (reset)
      !write_en |-> (shift_vec == '0) && (load_vec == '0))
      else $error("cells written without a write");

   a_full_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == suie_pkg::STAT_FULL) |-> rsp_ff.place == '0)
      else $error("full rejection with nonzero place");
`endif

endmodule

// File: sim/tb_sorted_union_insert_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_union_insert_engine
// Self-checking bench for the sorted insert engine. A shadow copy of the
// ordered store predicts every response and checks it in order. Stimulus
// covers directed edge cases, then builds, fills and random requests, with
// random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_union_insert_engine;

   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_GOAL   = 1050;
   localparam int SHOW_LIMIT  = 10;

   class sorted_store_tracker;
      logic signed [suie_pkg::VALUE_WIDTH-1:0] shadow_entries [suie_pkg::DEPTH];
      int                shadow_count;
      suie_pkg::rsp_type due_responses [$];
      int                mismatches;
      int                responses_seen;
      int                kind_hits [4];
      int                status_hits [4];

      function void take_request(suie_pkg::req_type r);
         suie_pkg::rsp_type                       e;
         logic signed [63:0]                      wide;
         logic signed [suie_pkg::VALUE_WIDTH-1:0] v;
         int                                      k;
         int                                      j;
         wide = 64'(r.value);
         v    = wide[suie_pkg::VALUE_WIDTH-1:0];
         e    = '0;
         k    = 0;
         case (r.kind)
            suie_pkg::KIND_APPEND: begin
               if (shadow_count >= suie_pkg::DEPTH) begin
                  e.status = suie_pkg::STAT_FULL;
               end else begin
                  shadow_entries[shadow_count] = v;
                  e.place = suie_pkg::TOTAL_W'(shadow_count);
                  shadow_count++;
               end
            end
            suie_pkg::KIND_MERGE: begin
               while (k < shadow_count && shadow_entries[k] < v) k++;
               if (k < shadow_count && shadow_entries[k] == v) begin
                  e.status = suie_pkg::STAT_DUP;
                  e.place  = suie_pkg::TOTAL_W'(k);
               end else if (shadow_count >= suie_pkg::DEPTH) begin
                  e.status = suie_pkg::STAT_FULL;
               end else begin
                  for (j = shadow_count; j > k; j--) shadow_entries[j] = shadow_entries[j-1];
                  shadow_entries[k] = v;
                  e.place = suie_pkg::TOTAL_W'(k);
                  shadow_count++;
               end
            end
            suie_pkg::KIND_CLEAR: begin
               shadow_count = 0;
            end
            default: begin
               if (int'(r.index) < shadow_count) begin
                  wide = 64'(shadow_entries[r.index]);
                  e.read_value = wide[suie_pkg::DATA_W-1:0];
               end else begin
                  e.status = suie_pkg::STAT_RANGE;
               end
            end
         endcase
         e.entry_total = suie_pkg::TOTAL_W'(shadow_count);
         kind_hits[r.kind]++;
         status_hits[e.status]++;
         due_responses.push_back(e);
      endfunction

      function void match_response(suie_pkg::rsp_type got);
         suie_pkg::rsp_type want;
         bit                bad;
         responses_seen++;
         if (due_responses.size() == 0) begin
            if (mismatches < SHOW_LIMIT)
               $display("ERROR: unexpected response: value %h total %0d status %0d place %0d",
                        got.read_value, got.entry_total, got.status, got.place);
            mismatches++;
            return;
         end
         want = due_responses.pop_front();
         bad  = (got.read_value !== want.read_value) || (got.entry_total !== want.entry_total) ||
                (got.status !== want.status) || (got.place !== want.place);
         if (bad) begin
            if (mismatches < SHOW_LIMIT) begin
               $display("ERROR: response %0d expected value %h total %0d status %0d place %0d",
                        responses_seen, want.read_value, want.entry_total, want.status,
                        want.place);
               $display("       got                value %h total %0d status %0d place %0d",
                        got.read_value, got.entry_total, got.status, got.place);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   suie_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   suie_pkg::rsp_type rsp_payload;

   bit calm;
   bit hold_go;
   bit hold_done;
   int sent;

   sorted_store_tracker tracker = new();

   sorted_union_insert_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic suie_pkg::req_type make_request(suie_pkg::kind_type k,
                                                      logic signed [31:0] v, logic [5:0] i);
      suie_pkg::req_type r;
      r.kind  = k;
      r.value = v;
      r.index = i;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_value(int mode);
      logic signed [31:0] v;
      case (mode)
         0: begin
            v = $urandom_range(0, 40);
            v = v - 20;
         end
         1: v = $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = -1;
               3:       v = 0;
               default: v = 1;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_request(input suie_pkg::req_type r);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.take_request(r);
      sent++;
      @(negedge clock);
   endtask

   // receiver: random stalls, one long hold-off
   initial begin
      while (reset) @(negedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_response(rsp_payload);
   end

   initial begin
      #400_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int       ep;
      int       n;
      int       mode;
      int       pick;
      logic [5:0] idx;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(make_request(suie_pkg::KIND_READ,  32'h1234_5678, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 0, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 32'sh8000_0000, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 32'sh7FFF_FFFF, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 0, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, -5, 6'd0));
      send_request(make_request(suie_pkg::KIND_APPEND, 32'sh7FFF_FFFF, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 32'sh7FFF_FFFF, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 32'sh7FFF_FFFE, 6'd0));
      send_request(make_request(suie_pkg::KIND_READ,  0, 6'd0));
      send_request(make_request(suie_pkg::KIND_READ,  0, 6'd5));
      send_request(make_request(suie_pkg::KIND_READ,  0, 6'd6));
      send_request(make_request(suie_pkg::KIND_READ,  0, 6'd63));
      send_request(make_request(suie_pkg::KIND_APPEND, 32'h5A5A_A5A5, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, 1, 6'd0));
      send_request(make_request(suie_pkg::KIND_CLEAR, -1, 6'd63));
      send_request(make_request(suie_pkg::KIND_READ,  0, 6'd0));
      send_request(make_request(suie_pkg::KIND_APPEND, -1, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, -1, 6'd0));
      send_request(make_request(suie_pkg::KIND_MERGE, -2, 6'd0));
      send_request(make_request(suie_pkg::KIND_READ,  -1, 6'd1));
      send_request(make_request(suie_pkg::KIND_MERGE, 32'sh8000_0000, 6'd0));

      while (sent < ITEM_GOAL) begin
         calm = (sent >= 400 && sent < 600);
         if (sent >= 700) hold_go = 1'b1;
         ep = (sent < 40) ? 4 : $urandom_range(0, 9);
         if (ep <= 3) begin
            send_request(make_request(suie_pkg::KIND_CLEAR, $urandom,
                                      6'($urandom_range(0, 63))));
            n    = $urandom_range(4, 70);
            mode = $urandom_range(0, 2);
            repeat (n) begin
               pick = $urandom_range(0, 99);
               idx  = (tracker.shadow_count > 63) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, tracker.shadow_count));
               if (pick < 25)
                  send_request(make_request(suie_pkg::KIND_READ, $urandom, idx));
               else if (pick < 35)
                  send_request(make_request(suie_pkg::KIND_APPEND, pick_value(mode), idx));
               else
                  send_request(make_request(suie_pkg::KIND_MERGE, pick_value(mode), idx));
            end
         end else if (ep <= 5) begin
            send_request(make_request(suie_pkg::KIND_CLEAR, $urandom,
                                      6'($urandom_range(0, 63))));
            while (tracker.shadow_count < suie_pkg::DEPTH)
               send_request(make_request(($urandom_range(0, 3) == 0) ? suie_pkg::KIND_APPEND
                                                                     : suie_pkg::KIND_MERGE,
                                         pick_value(1), 6'($urandom_range(0, 63))));
            repeat ($urandom_range(4, 10)) begin
               idx = 6'($urandom_range(0, 63));
               case ($urandom_range(0, 3))
                  0: send_request(make_request(suie_pkg::KIND_MERGE,
                        tracker.shadow_entries[$urandom_range(0, suie_pkg::DEPTH-1)], idx));
                  1: send_request(make_request(suie_pkg::KIND_MERGE, pick_value(1), idx));
                  2: send_request(make_request(suie_pkg::KIND_APPEND, pick_value(2), idx));
                  default: send_request(make_request(suie_pkg::KIND_READ, $urandom, idx));
               endcase
            end
         end else begin
            repeat (20)
               send_request(make_request(suie_pkg::kind_type'($urandom_range(0, 3)), $urandom,
                                         6'($urandom_range(0, 63))));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("summary: %0d requests (append %0d, merge %0d, clear %0d, read %0d), %0d checked",
               sent, tracker.kind_hits[suie_pkg::KIND_APPEND],
               tracker.kind_hits[suie_pkg::KIND_MERGE],
               tracker.kind_hits[suie_pkg::KIND_CLEAR], tracker.kind_hits[suie_pkg::KIND_READ],
               tracker.responses_seen);
      $display("summary: done %0d, duplicate %0d, full %0d, out of range %0d, mismatches %0d",
               tracker.status_hits[suie_pkg::STAT_DONE], tracker.status_hits[suie_pkg::STAT_DUP],
               tracker.status_hits[suie_pkg::STAT_FULL],
               tracker.status_hits[suie_pkg::STAT_RANGE], tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
design/suie_pkg.sv
design/suie_cell.sv
design/suie_locate.sv
design/sorted_union_insert_engine.sv
sim/tb_sorted_union_insert_engine.sv
